// ----- design/mat4_vector_transform_defines.svh -----
// ----------------------------------------------------------------------------
// mat4_vector_transform_defines
// Assertion macros used by the vertex transform RTL.
// ----------------------------------------------------------------------------
`ifndef MAT4_VECTOR_TRANSFORM_DEFINES_SVH
`define MAT4_VECTOR_TRANSFORM_DEFINES_SVH

// same-cycle implication, checked out of reset
`define M4VT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define M4VT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/m4vt_pkg.sv -----
// ----------------------------------------------------------------------------
// m4vt_pkg
// Shared constants and types of the 4x4 matrix vector transform.
// ----------------------------------------------------------------------------
package m4vt_pkg;

  localparam int unsigned ELEM_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 8;
  localparam int unsigned REG_WIDTH      = 64;
  localparam int unsigned NUM_ROWS       = 4;
  localparam int unsigned CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_ZERO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_THREE = 3'd3;

  // load enables of the three pipeline stages
  typedef struct packed {
    logic ld_mul;
    logic ld_sum;
    logic ld_out;
  } m4vt_stage_en_t;

endpackage

// ----- design/m4vt_if.sv -----
// ----------------------------------------------------------------------------
// m4vt_if
// Valid/ready channels for input vectors and transformed results.
// ----------------------------------------------------------------------------
interface m4vt_in_if
  import m4vt_pkg::*;
#(
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] vec_x;
  logic signed [ELEM_WIDTH-1:0] vec_y;
  logic signed [ELEM_WIDTH-1:0] vec_z;
  logic signed [ELEM_WIDTH-1:0] vec_w;
  logic                         three_only;

  modport source (output valid, vec_x, vec_y, vec_z, vec_w, three_only, input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, vec_w, three_only, output ready);
endinterface

interface m4vt_out_if
  import m4vt_pkg::*;
#(
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] res_x;
  logic signed [ELEM_WIDTH-1:0] res_y;
  logic signed [ELEM_WIDTH-1:0] res_z;
  logic signed [ELEM_WIDTH-1:0] res_w;
  logic                         saturated;

  modport source (output valid, res_x, res_y, res_z, res_w, saturated, input ready);
  modport sink   (input valid, res_x, res_y, res_z, res_w, saturated, output ready);
endinterface

// ----- design/m4vt_dot_lane.sv -----
// ----------------------------------------------------------------------------
// m4vt_dot_lane
// One matrix row dotted with the vector: multiply, sum, and a combined round
// and saturate, each in a register stage of its own.
// ----------------------------------------------------------------------------
module m4vt_dot_lane
  import m4vt_pkg::*;
#(
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  m4vt_stage_en_t                      en_i,
  input  logic [REG_WIDTH-1:0]                row_i,
  input  logic [NUM_ROWS-1:0][ELEM_WIDTH-1:0] vec_i,
  input  logic                                use_w_i,
  input  logic                                lane_on_i,
  output logic signed [ELEM_WIDTH-1:0]        res_o,
  output logic                                sat_o
);

  localparam int unsigned PW  = 2 * ELEM_WIDTH;
  localparam int unsigned SW  = PW + 2;
  localparam int unsigned EXT = (NUM_ROWS * ELEM_WIDTH > REG_WIDTH) ?
                                NUM_ROWS * ELEM_WIDTH : REG_WIDTH;

  localparam logic [SW-1:0] HALF = (SW'(1) << FRAC_BITS) >> 1;
  localparam logic signed [SW-1:0] MAXV = {{(SW-ELEM_WIDTH+1){1'b0}}, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-ELEM_WIDTH+1){1'b1}}, {(ELEM_WIDTH-1){1'b0}}};

  logic [EXT-1:0]          row_ext;
  logic signed [PW-1:0]    prod_d [NUM_ROWS];
  logic signed [PW-1:0]    prod_q [NUM_ROWS];
  logic signed [SW-1:0]    sum_d;
  logic signed [SW-1:0]    sum_q;
  logic signed [SW-1:0]    rnd;
  logic signed [SW-1:0]    shf;
  logic signed [ELEM_WIDTH-1:0] res_d;
  logic                    sat_d;
  logic signed [ELEM_WIDTH-1:0] res_q;
  logic                    sat_q;

  // element bits beyond the register read as zero
  assign row_ext = EXT'(row_i);

  always_comb begin
    for (int k = 0; k < NUM_ROWS; k++) begin
      if (lane_on_i && (k < NUM_ROWS - 1 || use_w_i)) begin
        prod_d[k] = $signed(row_ext[ELEM_WIDTH*k +: ELEM_WIDTH]) * $signed(vec_i[k]);
      end else begin
        prod_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld_mul) begin
      for (int k = 0; k < NUM_ROWS; k++) begin
        prod_q[k] <= prod_d[k];
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < NUM_ROWS; k++) begin
      sum_d = sum_d + SW'(prod_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld_sum) begin
      sum_q <= sum_d;
    end
  end

  // round half up, then clamp
  always_comb begin
    rnd   = sum_q + $signed(HALF);
    shf   = rnd >>> FRAC_BITS;
    sat_d = 1'b0;
    if (shf > MAXV) begin
      res_d = MAXV[ELEM_WIDTH-1:0];
      sat_d = 1'b1;
    end else if (shf < MINV) begin
      res_d = MINV[ELEM_WIDTH-1:0];
      sat_d = 1'b1;
    end else begin
      res_d = shf[ELEM_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld_out) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

// ----- design/mat4_vector_transform.sv -----
// ----------------------------------------------------------------------------
// mat4_vector_transform
// Pipeline: an accepted vector passes the product, sum and result registers.
// Throughput: one vector per cycle while the sink is ready; the stage registers
// (product, sum, rounded result) each advance whenever the stage after them frees up.
// Reset: valid bits clear, the row registers return to the identity matrix.
// ----------------------------------------------------------------------------
`include "mat4_vector_transform_defines.svh"

module mat4_vector_transform
  import m4vt_pkg::*;
#(
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_WIDTH-1:0] cfg_data_i,
  m4vt_in_if.sink              in_if,
  m4vt_out_if.source           out_if
);

  localparam int unsigned EXT = (NUM_ROWS * ELEM_WIDTH > REG_WIDTH) ?
                                NUM_ROWS * ELEM_WIDTH : REG_WIDTH;

  logic [NUM_ROWS-1:0][REG_WIDTH-1:0]  row_q;
  logic [NUM_ROWS-1:0][ELEM_WIDTH-1:0] vec;
  logic [NUM_ROWS-1:0][ELEM_WIDTH-1:0] res;
  logic [NUM_ROWS-1:0]                 sat;
  m4vt_stage_en_t                      en;
  logic                                mul_vld_q;
  logic                                sum_vld_q;
  logic                                out_vld_q;

  function automatic logic [REG_WIDTH-1:0] id_row(int unsigned i);
    logic [EXT-1:0] v;
    v = '0;
    if (FRAC_BITS < ELEM_WIDTH) begin
      v[ELEM_WIDTH*i + FRAC_BITS] = 1'b1;
    end
    return v[REG_WIDTH-1:0];
  endfunction

  // matrix rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        row_q[i] <= id_row(i);
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW_ZERO:  row_q[0] <= cfg_data_i;
        REG_ROW_ONE:   row_q[1] <= cfg_data_i;
        REG_ROW_TWO:   row_q[2] <= cfg_data_i;
        REG_ROW_THREE: row_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a stage loads when empty or when the stage after it loads
  assign en.ld_out = !out_vld_q || out_if.ready;
  assign en.ld_sum = !sum_vld_q || en.ld_out;
  assign en.ld_mul = !mul_vld_q || en.ld_sum;
  assign in_if.ready = en.ld_mul;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      sum_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en.ld_mul) mul_vld_q <= in_if.valid;
      if (en.ld_sum) sum_vld_q <= mul_vld_q;
      if (en.ld_out) out_vld_q <= sum_vld_q;
    end
  end

  assign vec[0] = in_if.vec_x;
  assign vec[1] = in_if.vec_y;
  assign vec[2] = in_if.vec_z;
  assign vec[3] = in_if.vec_w;

  for (genvar i = 0; i < NUM_ROWS; i++) begin : g_lane
    m4vt_dot_lane #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .en_i      (en),
      .row_i     (row_q[i]),
      .vec_i     (vec),
      .use_w_i   (!in_if.three_only),
      .lane_on_i ((i < NUM_ROWS - 1) || !in_if.three_only),
      .res_o     (res[i]),
      .sat_o     (sat[i])
    );
  end

  assign out_if.valid     = out_vld_q;
  assign out_if.res_x     = res[0];
  assign out_if.res_y     = res[1];
  assign out_if.res_z     = res[2];
  assign out_if.res_w     = res[3];
  assign out_if.saturated = |sat;

  `M4VT_ASSERT_NOW(a_ready_follows_sink, clk_i, rst_ni, out_if.ready, in_if.ready, "input blocked while sink takes words")
  `M4VT_ASSERT_NOW(a_full_stall, clk_i, rst_ni, mul_vld_q && sum_vld_q && out_vld_q && !out_if.ready, !in_if.ready, "word accepted into full pipeline")
  `M4VT_ASSERT_NEXT(a_accept_tracked, clk_i, rst_ni, in_if.valid && in_if.ready, mul_vld_q, "accepted word lost at first stage")

endmodule
